>>> src/particle_motion_step_defines.svh
// Assertion macros used by the checker file.
`ifndef PARTICLE_MOTION_STEP_DEFINES_SVH
`define PARTICLE_MOTION_STEP_DEFINES_SVH

// Whenever ante holds, cons must hold in the same cycle or as the sequence says.
`define PMS_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("particle_motion_step assertion failed");

// The expression must never hold outside reset.
`define PMS_ASSERT_NEVER(name, expr) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("particle_motion_step assertion failed");

`endif

>>> src/pms_pkg.sv
package pms_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ONE       = 1 << FRAC_BITS;

  localparam int K_GRAV   = (ONE + 50) / 100;
  localparam int K_ABS_H  = (9 * ONE + 5) / 10;
  localparam int K_ABS_D  = (ONE + 2) / 5;
  localparam int K_INNER  = (ONE + 5) / 10;
  localparam int K_OUTER  = (11 * ONE + 1) / 2;
  localparam int K_SPAN   = K_OUTER - K_INNER;
  localparam int K_POWER  = (3 * ONE + 100) / 200;
  localparam int K_REST_Z = (ONE + 500) / 1000;

  localparam int W      = 32;
  localparam int AGE_W  = 31;
  localparam int DT_W   = 20;
  localparam int GM_W   = 21;
  localparam int DAMP_W = 17;
  localparam int LIFE_W = 31;
  localparam int IDX_W  = 3;

  localparam int MAG_W   = $clog2(K_OUTER);
  localparam int SUM_W   = 2 * MAG_W + 1;
  localparam int DIST_W  = MAG_W + 1;
  localparam int Q_W     = FRAC_BITS + 1;
  localparam int DIR_W   = Q_W + 1;
  localparam int MD_W    = DIR_W;
  localparam int XNUM_W  = MAG_W + FRAC_BITS;
  localparam int TOT_W   = $clog2(K_POWER + 1);
  localparam int KG_W    = $clog2(K_GRAV + 1);
  localparam int G1_W    = KG_W + DT_W - FRAC_BITS;
  localparam int G_W     = G1_W + GM_W - FRAC_BITS;
  localparam int M_W     = W + DT_W - FRAC_BITS;

  // The ramp ratio is a multiply by the rounded-up reciprocal of the span.
  // The shift equals the bits of the operand and of the span together,
  // so the floored product equals the exact quotient.
  localparam int     RCP_SH = DIST_W + $clog2(K_SPAN + 1);
  localparam longint RCP_M  = ((longint'(1) << (RCP_SH + FRAC_BITS)) + K_SPAN - 1) / K_SPAN;
  localparam int     RCP_W  = $clog2(RCP_M + 1);

  localparam int LATENCY = 4 + DIST_W + Q_W + 11;

  typedef logic [IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_GRAVITY_MULT = 3'd0;
  localparam reg_idx_t REG_AIR_DAMPING  = 3'd1;
  localparam reg_idx_t REG_HIT_DAMPING  = 3'd2;
  localparam reg_idx_t REG_LIFETIME_MAX = 3'd3;

  typedef struct packed {
    logic [2:0][W-1:0]       p;
    logic [2:0][W-1:0]       v;
    logic [AGE_W-1:0]        age;
    logic                    age_ok;
    logic [DT_W-1:0]         dt;
    logic [G1_W-1:0]         g1;
    logic [G_W-1:0]          g;
    logic [1:0][W:0]         d;
    logic                    near;
    logic [1:0]              neg;
    logic [1:0][MAG_W-1:0]   mag;
    logic [1:0][2*MAG_W-1:0] sq;
    logic [SUM_W-1:0]        sum;
    logic [DIST_W-1:0]       dlen;
    logic [Q_W-1:0]          rq;
    logic                    alive;
    logic [Q_W-1:0]          t;
    logic [1:0][DIR_W-1:0]   dir;
    logic [TOT_W-1:0]        total;
    logic [1:0][MD_W-1:0]    md;
    logic [2:0][W-1:0]       f;
    logic [2:0][M_W-1:0]     m;
    logic                    bounce;
  } ctx_t;

  function automatic logic [W-1:0] sat32(input logic signed [47:0] x);
    if (x > 48'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end
    if (x < -48'sd2147483648) begin
      return 32'h8000_0000;
    end
    return x[W-1:0];
  endfunction

endpackage

>>> src/pms_delay.sv
module pms_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  output logic [WIDTH-1:0] out_data
);

  logic             vld [DEPTH+1];
  logic [WIDTH-1:0] dat [DEPTH+1];

  assign vld[0] = in_valid;
  assign dat[0] = in_data;

  for (genvar k = 0; k < DEPTH; k++) begin : g_tap
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      dat[k+1] <= dat[k];
    end
  end

  assign out_valid = vld[DEPTH];
  assign out_data  = dat[DEPTH];

endmodule

>>> src/pms_isqrt.sv
module pms_isqrt #(
  parameter int IN_W  = pms_pkg::SUM_W,
  parameter int OUT_W = pms_pkg::DIST_W
) (
  input  logic             clk,
  input  logic [IN_W-1:0]  radicand,
  output logic [OUT_W-1:0] root
);

  localparam int R_W = IN_W + 1;

  logic [R_W-1:0] rem [OUT_W+1];
  logic [R_W-1:0] res [OUT_W+1];

  assign rem[0] = R_W'(radicand);
  assign res[0] = '0;

  // One result bit per stage, from the top bit down.
  for (genvar k = 0; k < OUT_W; k++) begin : g_stage
    localparam logic [R_W-1:0] BIT = R_W'(1) << (2 * (OUT_W - 1 - k));
    logic [R_W-1:0] trial;
    logic           take;

    always_comb begin
      trial = res[k] + BIT;
      take  = rem[k] >= trial;
    end

    always_ff @(posedge clk) begin
      if (take) begin
        rem[k+1] <= rem[k] - trial;
        res[k+1] <= (res[k] >> 1) + BIT;
      end else begin
        rem[k+1] <= rem[k];
        res[k+1] <= res[k] >> 1;
      end
    end
  end

  assign root = res[OUT_W][OUT_W-1:0];

endmodule

>>> src/pms_div.sv
module pms_div #(
  parameter int N_W = pms_pkg::XNUM_W,
  parameter int D_W = pms_pkg::DIST_W,
  parameter int Q_W = pms_pkg::Q_W
) (
  input  logic           clk,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  output logic [Q_W-1:0] quo
);

  localparam int X_W = N_W + Q_W + D_W;

  logic [N_W-1:0] rem [Q_W+1];
  logic [D_W-1:0] dv  [Q_W+1];
  logic [Q_W-1:0] qb  [Q_W+1];

  assign rem[0] = num;
  assign dv[0]  = den;
  assign qb[0]  = '0;

  // Restoring division, one quotient bit per stage, top bit first.
  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int SH = Q_W - 1 - k;
    logic [X_W-1:0] trial;
    logic [X_W-1:0] remx;
    logic           take;

    always_comb begin
      trial = X_W'(dv[k]) << SH;
      remx  = X_W'(rem[k]);
      take  = remx >= trial;
    end

    always_ff @(posedge clk) begin
      rem[k+1] <= take ? N_W'(remx - trial) : rem[k];
      qb[k+1]  <= take ? (qb[k] | (Q_W'(1) << SH)) : qb[k];
      dv[k+1]  <= dv[k];
    end
  end

  assign quo = qb[Q_W];

endmodule

>>> src/particle_motion_step.sv
// Particle motion step: one particle is updated per input word.
// A word is taken at a rising edge where start is high and busy is low.
// busy is high only during reset, so a new particle can be started in
// every cycle. Each word carries the particle state, the frame step, the
// elapsed time and the attractor position.
// Exactly one result word leaves for every word taken, in order, with done
// high for one cycle. The pipeline holds the pipelined square root (one
// bit per stage, 20 stages) followed by the pipelined dividers (17
// stages), plus the fixed-point arithmetic stages around them;
// throughput is one particle per cycle.
// The configuration channel takes a write whenever cfg_valid and cfg_ready
// are high; registers should be changed only while no particle is in flight.
// Unknown indexes are ignored.
// A synchronous reset clears every valid bit and restores the register
// defaults; words in flight are dropped. The receiver cannot stall the
// block, so results are never held back.
module particle_motion_step (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [31:0]           pos_x,
  input  logic signed [31:0]           pos_y,
  input  logic signed [31:0]           pos_z,
  input  logic signed [31:0]           vel_x,
  input  logic signed [31:0]           vel_y,
  input  logic signed [31:0]           vel_z,
  input  logic [30:0]                  age,
  input  logic [19:0]                  step_time,
  input  logic [19:0]                  elapsed_time,
  input  logic signed [31:0]           attract_x,
  input  logic signed [31:0]           attract_y,
  output logic                         done,
  output logic                         alive,
  output logic signed [31:0]           new_pos_x,
  output logic signed [31:0]           new_pos_y,
  output logic signed [31:0]           new_pos_z,
  output logic signed [31:0]           new_vel_x,
  output logic signed [31:0]           new_vel_y,
  output logic signed [31:0]           new_vel_z,
  output logic [30:0]                  new_age,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pms_pkg::IDX_W-1:0]    cfg_index,
  input  logic [31:0]                  cfg_data
);

  localparam int W    = pms_pkg::W;
  localparam int FB   = pms_pkg::FRAC_BITS;
  localparam int CW   = $bits(pms_pkg::ctx_t);

  logic [pms_pkg::GM_W-1:0]   gravity_mult;
  logic [pms_pkg::DAMP_W-1:0] air_damping;
  logic [pms_pkg::DAMP_W-1:0] hit_damping;
  logic [pms_pkg::LIFE_W-1:0] lifetime_max;

  assign busy      = rst;
  assign cfg_ready = ~rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_mult <= pms_pkg::GM_W'(65536);
      air_damping  <= pms_pkg::DAMP_W'(65536);
      hit_damping  <= pms_pkg::DAMP_W'(32768);
      lifetime_max <= pms_pkg::LIFE_W'(131072);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pms_pkg::REG_GRAVITY_MULT: gravity_mult <= cfg_data[pms_pkg::GM_W-1:0];
        pms_pkg::REG_AIR_DAMPING:  air_damping  <= cfg_data[pms_pkg::DAMP_W-1:0];
        pms_pkg::REG_HIT_DAMPING:  hit_damping  <= cfg_data[pms_pkg::DAMP_W-1:0];
        pms_pkg::REG_LIFETIME_MAX: lifetime_max <= cfg_data[pms_pkg::LIFE_W-1:0];
        default: ;
      endcase
    end
  end

  pms_pkg::ctx_t n0, c0, n1, c1, n2, c2, n3, c3;
  pms_pkg::ctx_t ca, cc, cb;
  pms_pkg::ctx_t n4, c4, n5, c5, n6, c6, n7, c7, n8, c8;
  pms_pkg::ctx_t n9, c9, n10, c10, n11, c11, n12, c12, n13, c13;
  logic v0, v1, v2, v3, va, vb, v4, v5, v6, v7, v8, v9, v10, v11, v12, v13;
  logic [CW-1:0] ca_bits, cb_bits;

  logic [pms_pkg::AGE_W:0]              age_sum;
  logic [pms_pkg::KG_W+pms_pkg::DT_W-1:0] g1_prod;

  always_comb begin
    n0      = '0;
    n0.p[0] = pos_x;
    n0.p[1] = pos_y;
    n0.p[2] = pos_z;
    n0.v[0] = vel_x;
    n0.v[1] = vel_y;
    n0.v[2] = vel_z;
    n0.dt   = step_time;
    age_sum = {1'b0, age} + (pms_pkg::AGE_W + 1)'(elapsed_time);
    n0.age  = age_sum[pms_pkg::AGE_W] ? '1 : age_sum[pms_pkg::AGE_W-1:0];
    n0.age_ok = n0.age < lifetime_max;
    n0.d[0] = {attract_x[31], attract_x} - {pos_x[31], pos_x};
    n0.d[1] = {attract_y[31], attract_y} - {pos_y[31], pos_y};
    g1_prod = pms_pkg::KG_W'(pms_pkg::K_GRAV) * step_time;
    n0.g1   = pms_pkg::G1_W'(g1_prod >> FB);
  end

  logic [1:0][W:0] absd;
  logic [pms_pkg::G1_W+pms_pkg::GM_W-1:0] g_prod;

  always_comb begin
    n1 = c0;
    for (int i = 0; i < 2; i++) begin
      n1.neg[i] = c0.d[i][W];
      absd[i]   = c0.d[i][W] ? -c0.d[i] : c0.d[i];
      n1.mag[i] = absd[i][pms_pkg::MAG_W-1:0];
    end
    n1.near = (absd[0] < (W + 1)'(pms_pkg::K_OUTER)) &&
              (absd[1] < (W + 1)'(pms_pkg::K_OUTER));
    g_prod  = c0.g1 * gravity_mult;
    n1.g    = pms_pkg::G_W'(g_prod >> FB);
  end

  always_comb begin
    n2 = c1;
    for (int i = 0; i < 2; i++) begin
      n2.sq[i] = (2 * pms_pkg::MAG_W)'(c1.mag[i]) * (2 * pms_pkg::MAG_W)'(c1.mag[i]);
    end
  end

  always_comb begin
    n3     = c2;
    n3.sum = c2.near ? (pms_pkg::SUM_W'(c2.sq[0]) + pms_pkg::SUM_W'(c2.sq[1])) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v0 <= start && !busy;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
    c0 <= n0;
    c1 <= n1;
    c2 <= n2;
    c3 <= n3;
  end

  logic [pms_pkg::DIST_W-1:0] dlen;

  pms_isqrt #(
    .IN_W  (pms_pkg::SUM_W),
    .OUT_W (pms_pkg::DIST_W)
  ) u_isqrt (
    .clk      (clk),
    .radicand (c3.sum),
    .root     (dlen)
  );

  pms_delay #(
    .WIDTH (CW),
    .DEPTH (pms_pkg::DIST_W)
  ) u_dly_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .in_data   (c3),
    .out_valid (va),
    .out_data  (ca_bits)
  );

  logic [pms_pkg::DIST_W-1:0]               dist_off;
  logic [pms_pkg::DIST_W+pms_pkg::RCP_W-1:0] rcp_prod;
  logic [pms_pkg::Q_W:0]                    rcp_q;
  logic [pms_pkg::Q_W-1:0]                  q_x, q_y;

  always_comb begin
    ca       = pms_pkg::ctx_t'(ca_bits);
    cc       = ca;
    cc.dlen  = dlen;
    dist_off = (dlen > pms_pkg::DIST_W'(pms_pkg::K_INNER)) ?
               dlen - pms_pkg::DIST_W'(pms_pkg::K_INNER) : '0;
    rcp_prod = (pms_pkg::DIST_W + pms_pkg::RCP_W)'(dist_off) *
               pms_pkg::RCP_W'(pms_pkg::RCP_M);
    rcp_q    = (pms_pkg::Q_W + 1)'(rcp_prod >> pms_pkg::RCP_SH);
    cc.rq    = (rcp_q > (pms_pkg::Q_W + 1)'(pms_pkg::ONE)) ?
               pms_pkg::Q_W'(pms_pkg::ONE) : rcp_q[pms_pkg::Q_W-1:0];
  end

  pms_div #(
    .N_W (pms_pkg::XNUM_W),
    .D_W (pms_pkg::DIST_W),
    .Q_W (pms_pkg::Q_W)
  ) u_div_x (
    .clk (clk),
    .num ({ca.mag[0], {FB{1'b0}}}),
    .den (dlen),
    .quo (q_x)
  );

  pms_div #(
    .N_W (pms_pkg::XNUM_W),
    .D_W (pms_pkg::DIST_W),
    .Q_W (pms_pkg::Q_W)
  ) u_div_y (
    .clk (clk),
    .num ({ca.mag[1], {FB{1'b0}}}),
    .den (dlen),
    .quo (q_y)
  );

  pms_delay #(
    .WIDTH (CW),
    .DEPTH (pms_pkg::Q_W)
  ) u_dly_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (va),
    .in_data   (cc),
    .out_valid (vb),
    .out_data  (cb_bits)
  );

  always_comb begin
    cb      = pms_pkg::ctx_t'(cb_bits);
    n4      = cb;
    if (!cb.near) begin
      n4.t = '0;
    end else if (cb.dlen > pms_pkg::DIST_W'(pms_pkg::K_INNER)) begin
      n4.t = pms_pkg::Q_W'(pms_pkg::ONE) - cb.rq;
    end else begin
      n4.t = pms_pkg::Q_W'(pms_pkg::ONE);
    end
    n4.alive = cb.age_ok &&
               !(cb.near && (cb.dlen < pms_pkg::DIST_W'(pms_pkg::K_ABS_D)) &&
                 ($signed(cb.p[2]) < $signed(W'(pms_pkg::K_ABS_H))));
    if (cb.near && (cb.dlen != '0)) begin
      n4.dir[0] = cb.neg[0] ? -{1'b0, q_x} : {1'b0, q_x};
      n4.dir[1] = cb.neg[1] ? -{1'b0, q_y} : {1'b0, q_y};
    end else begin
      n4.dir = '0;
    end
  end

  logic [pms_pkg::Q_W+pms_pkg::TOT_W+FB-1:0] tot_prod;
  logic signed [pms_pkg::DIR_W+pms_pkg::Q_W:0] md_prod [2];

  always_comb begin
    n5       = c4;
    tot_prod = c4.t * (pms_pkg::TOT_W + FB)'(pms_pkg::K_POWER);
    n5.total = pms_pkg::TOT_W'(tot_prod >> FB);
    for (int i = 0; i < 2; i++) begin
      md_prod[i] = $signed(c4.dir[i]) * $signed({1'b0, c4.t});
      n5.md[i]   = pms_pkg::MD_W'(md_prod[i] >>> FB);
    end
  end

  logic signed [pms_pkg::MD_W+pms_pkg::TOT_W:0] f_prod [2];
  logic [pms_pkg::Q_W+pms_pkg::TOT_W-1:0]        fz_prod;

  always_comb begin
    n6 = c5;
    for (int i = 0; i < 2; i++) begin
      f_prod[i] = $signed(c5.md[i]) * $signed({1'b0, c5.total});
      n6.f[i]   = W'(f_prod[i] >>> FB);
    end
    fz_prod = (pms_pkg::Q_W'(pms_pkg::ONE) - c5.t) * c5.total;
    n6.f[2] = W'(fz_prod >> FB);
    if (!c5.near) begin
      n6.f = '0;
    end
  end

  logic signed [47:0] s7 [3];

  always_comb begin
    n7 = c6;
    for (int i = 0; i < 3; i++) begin
      s7[i]   = $signed(c6.v[i]) + $signed(c6.f[i]);
      n7.v[i] = pms_pkg::sat32(s7[i]);
    end
  end

  logic signed [47:0] s8;

  always_comb begin
    n8      = c7;
    s8      = $signed(c7.v[2]) - $signed({1'b0, c7.g});
    n8.v[2] = pms_pkg::sat32(s8);
  end

  logic signed [W+pms_pkg::DAMP_W:0] air_prod [3];

  always_comb begin
    n9 = c8;
    for (int i = 0; i < 3; i++) begin
      air_prod[i] = $signed(c8.v[i]) * $signed({1'b0, air_damping});
      n9.v[i]     = pms_pkg::sat32(48'(air_prod[i] >>> FB));
    end
  end

  logic signed [W+pms_pkg::DT_W:0] dt_prod [3];

  always_comb begin
    n10 = c9;
    for (int i = 0; i < 3; i++) begin
      dt_prod[i] = $signed(c9.v[i]) * $signed({1'b0, c9.dt});
      n10.m[i]   = pms_pkg::M_W'(dt_prod[i] >>> FB);
    end
  end

  logic signed [47:0] s11 [3];

  always_comb begin
    n11 = c10;
    for (int i = 0; i < 3; i++) begin
      s11[i]   = $signed(c10.p[i]) + $signed(c10.m[i]);
      n11.p[i] = pms_pkg::sat32(s11[i]);
    end
  end

  logic signed [47:0] neg_pz, neg_vz;

  always_comb begin
    n12        = c11;
    n12.bounce = $signed(c11.p[2]) <= 0;
    neg_pz     = -$signed(c11.p[2]);
    neg_vz     = -$signed(c11.v[2]);
    if (n12.bounce) begin
      n12.p[2] = pms_pkg::sat32(neg_pz);
      n12.v[2] = pms_pkg::sat32(neg_vz);
    end
  end

  logic signed [W+pms_pkg::DAMP_W:0] hit_prod [3];

  always_comb begin
    n13 = c12;
    for (int i = 0; i < 3; i++) begin
      hit_prod[i] = $signed(c12.v[i]) * $signed({1'b0, hit_damping});
      if (c12.bounce) begin
        n13.v[i] = pms_pkg::sat32(48'(hit_prod[i] >>> FB));
      end
    end
  end

  pms_pkg::ctx_t fin;
  logic          rest;

  always_comb begin
    fin  = c13;
    rest = c13.bounce && ($signed(c13.v[2]) <= $signed({1'b0, c13.g, 2'b00}));
    if (rest) begin
      fin.v[2] = '0;
      fin.p[2] = W'(pms_pkg::K_REST_Z);
    end
    if (!c13.alive) begin
      fin.p   = '0;
      fin.v   = '0;
      fin.age = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4   <= 1'b0;
      v5   <= 1'b0;
      v6   <= 1'b0;
      v7   <= 1'b0;
      v8   <= 1'b0;
      v9   <= 1'b0;
      v10  <= 1'b0;
      v11  <= 1'b0;
      v12  <= 1'b0;
      v13  <= 1'b0;
      done <= 1'b0;
    end else begin
      v4   <= vb;
      v5   <= v4;
      v6   <= v5;
      v7   <= v6;
      v8   <= v7;
      v9   <= v8;
      v10  <= v9;
      v11  <= v10;
      v12  <= v11;
      v13  <= v12;
      done <= v13;
    end
    c4        <= n4;
    c5        <= n5;
    c6        <= n6;
    c7        <= n7;
    c8        <= n8;
    c9        <= n9;
    c10       <= n10;
    c11       <= n11;
    c12       <= n12;
    c13       <= n13;
    alive     <= c13.alive;
    new_pos_x <= fin.p[0];
    new_pos_y <= fin.p[1];
    new_pos_z <= fin.p[2];
    new_vel_x <= fin.v[0];
    new_vel_y <= fin.v[1];
    new_vel_z <= fin.v[2];
    new_age   <= fin.age;
  end

endmodule

>>> src/pms_checker.sv
module pms_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic               alive,
  input logic signed [31:0] new_pos_x,
  input logic signed [31:0] new_pos_y,
  input logic signed [31:0] new_pos_z,
  input logic signed [31:0] new_vel_x,
  input logic signed [31:0] new_vel_y,
  input logic signed [31:0] new_vel_z,
  input logic [30:0]        new_age
);

`include "particle_motion_step_defines.svh"

  logic all_zero;

  assign all_zero = ({new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
                      new_age} == '0);

  // Every word taken comes back after the fixed pipeline latency.
  `PMS_ASSERT_IMPL(a_start_to_done, start && !busy, ##(pms_pkg::LATENCY) done)

  // No result appears without a word taken at the matching earlier cycle.
  `PMS_ASSERT_IMPL(a_done_has_start, done, $past(start && !busy, pms_pkg::LATENCY))

  // A removed particle reports all zero fields.
  `PMS_ASSERT_IMPL(a_removed_zero, done && !alive, all_zero)

  // The ground bounce keeps the reported height at or above zero.
  `PMS_ASSERT_NEVER(a_height_nonneg, done && new_pos_z[31])

endmodule

bind particle_motion_step pms_checker u_pms_checker (.*);

>>> dv/particle_motion_step_test.sv
`timescale 1ns / 100ps

module particle_motion_step_test;

  localparam pms_pkg::reg_idx_t UNUSED_REG = pms_pkg::reg_idx_t'(7);
  localparam longint U31_TOP = 64'h7FFF_FFFF;
  localparam longint S32_TOP = 64'sh7FFF_FFFF;
  localparam longint S32_BOT = -64'sh8000_0000;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    logic signed [31:0] px, py, pz, vx, vy, vz;
    logic [30:0] age;
    logic [19:0] dt, el;
    logic signed [31:0] ax, ay;
  } particle_t;

  typedef struct {
    logic alive;
    logic [31:0] px, py, pz, vx, vy, vz;
    logic [30:0] age;
  } update_t;

  typedef struct {
    particle_t p;
    bit removed;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0;
  logic signed [31:0] vel_x = 0, vel_y = 0, vel_z = 0;
  logic [30:0] age = 0;
  logic [19:0] step_time = 0, elapsed_time = 0;
  logic signed [31:0] attract_x = 0, attract_y = 0;
  logic done, alive;
  logic signed [31:0] new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z;
  logic [30:0] new_age;
  logic cfg_valid = 0;
  logic cfg_ready;
  pms_pkg::reg_idx_t cfg_index = '0;
  logic [31:0] cfg_data = 0;

  longint gravity_q, air_q, hit_q, life_q;
  update_t pending_updates[$];
  int errors = 0;
  int stall_cycles = 0;

  particle_motion_step dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  function automatic longint fx_mul(longint a, longint b);
    return (a * b) >>> pms_pkg::FRAC_BITS;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > S32_TOP) return S32_TOP;
    if (v < S32_BOT) return S32_BOT;
    return v;
  endfunction

  function automatic longint int_root(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic update_t predict_motion(particle_t it);
    update_t r = '{default: '0};
    longint p[3], v[3], f[3];
    longint a, dx, dy, g, t, rad, dirx, diry, total, rr;
    p[0] = it.px; p[1] = it.py; p[2] = it.pz;
    v[0] = it.vx; v[1] = it.vy; v[2] = it.vz;
    f[0] = 0; f[1] = 0; f[2] = 0;
    a = longint'(it.age) + longint'(it.el);
    if (a > U31_TOP) a = U31_TOP;
    if (a >= life_q) return r;
    dx = longint'(it.ax) - p[0];
    dy = longint'(it.ay) - p[1];
    if ((dx < 0 ? -dx : dx) < pms_pkg::K_OUTER &&
        (dy < 0 ? -dy : dy) < pms_pkg::K_OUTER) begin
      rad = int_root(dx * dx + dy * dy);
      if (rad < pms_pkg::K_ABS_D && p[2] < pms_pkg::K_ABS_H) return r;
      dirx = 0;
      diry = 0;
      if (rad > 0) begin
        dirx = (dx * pms_pkg::ONE) / rad;
        diry = (dy * pms_pkg::ONE) / rad;
      end
      if (rad > pms_pkg::K_INNER) begin
        rr = ((rad - pms_pkg::K_INNER) * pms_pkg::ONE) / pms_pkg::K_SPAN;
        if (rr > pms_pkg::ONE) rr = pms_pkg::ONE;
        t = pms_pkg::ONE - rr;
      end else begin
        t = pms_pkg::ONE;
      end
      total = fx_mul(t, pms_pkg::K_POWER);
      f[0] = fx_mul(fx_mul(dirx, t), total);
      f[1] = fx_mul(fx_mul(diry, t), total);
      f[2] = fx_mul(pms_pkg::ONE - t, total);
    end
    for (int i = 0; i < 3; i++) v[i] = clamp32(v[i] + f[i]);
    g = fx_mul(fx_mul(pms_pkg::K_GRAV, longint'(it.dt)), gravity_q);
    v[2] = clamp32(v[2] - g);
    for (int i = 0; i < 3; i++) begin
      v[i] = clamp32(fx_mul(v[i], air_q));
      p[i] = clamp32(p[i] + fx_mul(v[i], longint'(it.dt)));
    end
    if (p[2] <= 0) begin
      p[2] = clamp32(-p[2]);
      v[2] = clamp32(-v[2]);
      for (int i = 0; i < 3; i++) v[i] = clamp32(fx_mul(v[i], hit_q));
      if (v[2] <= g * 4) begin
        v[2] = 0;
        p[2] = pms_pkg::K_REST_Z;
      end
    end
    r.alive = 1;
    r.px = p[0][31:0]; r.py = p[1][31:0]; r.pz = p[2][31:0];
    r.vx = v[0][31:0]; r.vy = v[1][31:0]; r.vz = v[2][31:0];
    r.age = a[30:0];
    return r;
  endfunction

  function automatic particle_t make_particle(longint px, longint py, longint pz, longint vx,
                                              longint vy, longint vz, longint ag, longint dt,
                                              longint el, longint ax, longint ay);
    particle_t it;
    it.px = px; it.py = py; it.pz = pz;
    it.vx = vx; it.vy = vy; it.vz = vz;
    it.age = ag; it.dt = dt; it.el = el;
    it.ax = ax; it.ay = ay;
    return it;
  endfunction

  function automatic particle_t random_particle();
    particle_t it;
    int unsigned lim;
    if ($urandom_range(0, 4) == 0) begin
      it = make_particle($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      lim = (life_q > 0 && life_q < 64'h7FFF_0000) ? int'(life_q) : 262144;
      it.px = $signed($urandom_range(0, 1048576)) - 524288;
      it.py = $signed($urandom_range(0, 1048576)) - 524288;
      it.pz = $signed($urandom_range(0, 262144)) - 65536;
      it.vx = $signed($urandom_range(0, 524288)) - 262144;
      it.vy = $signed($urandom_range(0, 524288)) - 262144;
      it.vz = $signed($urandom_range(0, 524288)) - 262144;
      it.age = $urandom_range(0, lim);
      it.dt = $urandom_range(0, 16384);
      it.el = $urandom_range(0, 8192);
      it.ax = it.px + $signed($urandom_range(0, 786432)) - 393216;
      it.ay = it.py + $signed($urandom_range(0, 786432)) - 393216;
    end
    return it;
  endfunction

  task automatic write_reg(pms_pkg::reg_idx_t idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      pms_pkg::REG_GRAVITY_MULT: gravity_q = val & 32'h1F_FFFF;
      pms_pkg::REG_AIR_DAMPING:  air_q = val & 32'h1_FFFF;
      pms_pkg::REG_HIT_DAMPING:  hit_q = val & 32'h1_FFFF;
      pms_pkg::REG_LIFETIME_MAX: life_q = val & 32'h7FFF_FFFF;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_particle(particle_t it, bit removed);
    update_t dead = '{default: '0};
    start <= 1;
    pos_x <= it.px; pos_y <= it.py; pos_z <= it.pz;
    vel_x <= it.vx; vel_y <= it.vy; vel_z <= it.vz;
    age <= it.age; step_time <= it.dt; elapsed_time <= it.el;
    attract_x <= it.ax; attract_y <= it.ay;
    do @(posedge clk); while (busy);
    pending_updates.push_back(removed ? dead : predict_motion(it));
  endtask

  task automatic drain();
    start <= 0;
    while (pending_updates.size() != 0) @(posedge clk);
  endtask

  task automatic run_random(int count, bit with_gaps);
    for (int n = 0; n < count; n++) begin
      if (with_gaps && $urandom_range(0, 7) == 0) begin
        start <= 0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      send_particle(random_particle(), 0);
    end
    drain();
  endtask

  task automatic compare_field(string name, longint e, longint a);
    if (e != a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    update_t e;
    if (!rst && done) begin
      if (pending_updates.size() == 0) begin
        $error("result word with no particle outstanding");
        errors++;
      end else begin
        e = pending_updates.pop_front();
        compare_field("alive", e.alive, alive);
        compare_field("new_pos_x", e.px, new_pos_x[31:0]);
        compare_field("new_pos_y", e.py, new_pos_y[31:0]);
        compare_field("new_pos_z", e.pz, new_pos_z[31:0]);
        compare_field("new_vel_x", e.vx, new_vel_x[31:0]);
        compare_field("new_vel_y", e.vy, new_vel_y[31:0]);
        compare_field("new_vel_z", e.vz, new_vel_z[31:0]);
        compare_field("new_age", e.age, new_age);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("particle_motion_step test failed");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    gravity_q = 65536;
    air_q = 65536;
    hit_q = 32768;
    life_q = 131072;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    rows.push_back('{make_particle(0, 0, 65536, 65536, 0, 0, 0, 1092, 1092,
                                   1000000, 0), 0});
    rows.push_back('{make_particle(0, 0, 65536, 0, 0, 0, 131072, 1092, 0, 0, 0), 1});
    rows.push_back('{make_particle(0, 0, 65536, 0, 0, 0, 32'h7FFF_FFFF, 0, 20'hFFFFF,
                                   0, 0), 1});
    rows.push_back('{make_particle(4096, 4096, 0, 0, 0, 0, 0, 1092, 1092, 4096, 4096), 1});
    rows.push_back('{make_particle(4096, 4096, 1 << 20, 0, 0, 0, 0, 1092, 1092,
                                   4096, 4096), 0});
    rows.push_back('{make_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                   32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                   0, 20'hFFFFF, 0, 32'h8000_0000, 32'h7FFF_FFFF), 0});
    rows.push_back('{make_particle(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                   32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                   0, 20'hFFFFF, 0, 0, 0), 0});
    rows.push_back('{make_particle(0, 0, 100, 0, 0, -300000, 0, 4096, 0, 1 << 24, 0), 0});
    rows.push_back('{make_particle(0, 0, 0, 0, 0, 0, 0, 1092, 0, 1 << 24, 0), 0});
    rows.push_back('{make_particle(0, 0, 1 << 20, 0, 0, 0, 0, 1092, 0, 5000, 3000), 0});
    rows.push_back('{make_particle(0, 0, 1 << 20, 0, 0, 0, 0, 1092, 0, 200000, -100000), 0});
    rows.push_back('{make_particle(0, 0, 1 << 20, 0, 0, 0, 0, 1092, 0,
                                   -pms_pkg::K_OUTER + 1, pms_pkg::K_OUTER - 1), 0});
    rows.push_back('{make_particle(0, 0, 1 << 20, 0, 0, 0, 0, 1092, 0,
                                   pms_pkg::K_OUTER, 0), 0});
    rows.push_back('{make_particle(0, 0, 1 << 20, 0, 0, 0, 0, 1092, 0,
                                   0, -pms_pkg::K_OUTER), 0});
    rows.push_back('{make_particle(0, 0, 1 << 20, 0, 0, 0, 131071, 1092, 0, 0, 1 << 22), 0});
    foreach (rows[i]) send_particle(rows[i].p, rows[i].removed);
    drain();

    run_random(300, 1);

    write_reg(UNUSED_REG, 32'hFFFF_FFFF);
    write_reg(pms_pkg::REG_GRAVITY_MULT, 1048576);
    write_reg(pms_pkg::REG_AIR_DAMPING, 65536);
    write_reg(pms_pkg::REG_HIT_DAMPING, 65536);
    write_reg(pms_pkg::REG_LIFETIME_MAX, 32'h7FFF_FFFF);
    run_random(350, 1);

    write_reg(pms_pkg::REG_GRAVITY_MULT, 0);
    write_reg(pms_pkg::REG_AIR_DAMPING, 0);
    write_reg(pms_pkg::REG_HIT_DAMPING, 0);
    write_reg(pms_pkg::REG_LIFETIME_MAX, 0);
    run_random(30, 1);

    write_reg(pms_pkg::REG_LIFETIME_MAX, 196608);
    run_random(300, 1);

    write_reg(pms_pkg::REG_GRAVITY_MULT, $urandom_range(0, 1048576));
    write_reg(pms_pkg::REG_AIR_DAMPING, $urandom_range(0, 65536));
    write_reg(pms_pkg::REG_HIT_DAMPING, $urandom_range(0, 65536));
    write_reg(pms_pkg::REG_LIFETIME_MAX, $urandom_range(65536, 1 << 20));
    run_random(350, 1);

    write_reg(pms_pkg::REG_GRAVITY_MULT, 131072);
    write_reg(pms_pkg::REG_AIR_DAMPING, 64880);
    write_reg(pms_pkg::REG_HIT_DAMPING, 40000);
    write_reg(pms_pkg::REG_LIFETIME_MAX, 393216);
    run_random(350, 0);

    repeat (pms_pkg::LATENCY + 16) @(posedge clk);
    if (errors == 0 && pending_updates.size() == 0) begin
      $display("particle_motion_step test passed");
    end else begin
      $display("particle_motion_step test failed");
    end
    $finish;
  end

endmodule
